/* hw/rtl/assert_macros.svh */
// Assertion shorthands used by the azn_check checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define AZN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define AZN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/azn_pkg.sv */
`default_nettype none

package azn_pkg;

    localparam int AXIS_W       = 16;
    localparam int DEG_W        = 8;
    localparam int IDX_W        = 7;
    localparam int SEARCH_STEPS = 7;
    localparam int TAB_LAST     = 90;
    localparam int FRAC_W       = 32;

    localparam logic [DEG_W-1:0] DEG_NONE      = 8'd0;
    localparam logic [DEG_W-1:0] DEG_RIGHT     = 8'd90;
    localparam logic [DEG_W-1:0] DEG_HALF_TURN = 8'd180;

    localparam logic [63:0] Q31_ONE     = 64'd2147483648;
    localparam logic [63:0] COS_ONE_Q31 = 64'd2147156576;
    localparam logic [63:0] SIN_ONE_Q31 = 64'd37478757;
    localparam logic [63:0] Q31_HALF    = 64'd1073741824;

    // cos^2(d deg) in Q32; entry 0 stands for 1.0 and is handled as a shift
    typedef logic [FRAC_W-1:0] cos_sq_tab_t [0:TAB_LAST];

    typedef struct packed {
        logic vec_zero;
        logic z_zero;
        logic z_neg;
    } azn_flags_t;

    function automatic cos_sq_tab_t build_cos_sq();
        cos_sq_tab_t tab;
        logic [63:0] c;
        logic [63:0] s;
        logic [63:0] nc;
        logic [63:0] ns;
        logic [63:0] sq64;
        logic [63:0] cq [0:45];
        logic [63:0] sn [0:45];
        c = Q31_ONE;
        s = '0;
        cq[0] = c;
        sn[0] = s;
        for (int k = 1; k <= 45; k++)
        begin
            nc = (c * COS_ONE_Q31 - s * SIN_ONE_Q31 + Q31_HALF) >> 31;
            ns = (s * COS_ONE_Q31 + c * SIN_ONE_Q31 + Q31_HALF) >> 31;
            c = nc;
            s = ns;
            cq[k] = c;
            sn[k] = s;
        end
        for (int k = 0; k <= 45; k++)
        begin
            sq64 = cq[k] * cq[k];
            tab[k] = sq64[61:30];
        end
        for (int k = 46; k <= TAB_LAST; k++)
        begin
            sq64 = sn[TAB_LAST-k] * sn[TAB_LAST-k];
            tab[k] = sq64[61:30];
        end
        tab[0]        = '0;
        tab[30]       = 32'hC000_0000;
        tab[45]       = 32'h8000_0000;
        tab[60]       = 32'h4000_0000;
        tab[TAB_LAST] = '0;
        return tab;
    endfunction

    localparam cos_sq_tab_t COS_SQ_Q32 = build_cos_sq();

endpackage

`default_nettype wire

/* hw/rtl/azn_ifaces.sv */
`default_nettype none

interface azn_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [azn_pkg::AXIS_W-1:0]   x_sample;
    logic signed [azn_pkg::AXIS_W-1:0]   y_sample;
    logic signed [azn_pkg::AXIS_W-1:0]   z_sample;

    modport source (output valid, output x_sample, output y_sample, output z_sample,
                    input ready);
    modport sink   (input valid, input x_sample, input y_sample, input z_sample,
                    output ready);
endinterface

interface azn_result_if;
    logic                              valid;
    logic                              ready;
    logic [azn_pkg::DEG_W-1:0]         zenith_degrees;
    logic                              angle_valid;

    modport source (output valid, output zenith_degrees, output angle_valid, input ready);
    modport sink   (input valid, input zenith_degrees, input angle_valid, output ready);
endinterface

`default_nettype wire

/* hw/rtl/accel_zenith_angle.sv */
`default_nettype none

// Zenith angle of a three-axis accelerometer sample: acos(z/|v|) in whole
// degrees, truncated, 0..180; an all-zero sample gives 0 with angle_valid low.
// Only the low SAMPLE_BITS bits of each axis are used, as two's complement.
// Takes one request per clock while the result side does not stall, and
// returns each result through three front stages (magnitudes, squares,
// |v|^2), then seven bisection cells over a 91-entry cos^2 table, three
// stages each around one 32x32 multiply, then the output register. A stall
// on the result side fills empty stages first, so requests keep being taken
// until the pipeline is full.
module accel_zenith_angle #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    azn_sample_if.sink      sample,
    azn_result_if.source    result
);

    localparam int R2_W  = 2*SAMPLE_BITS;
    localparam int Z2_W  = 2*SAMPLE_BITS-1;
    localparam int NS    = azn_pkg::SEARCH_STEPS;
    localparam int IW    = azn_pkg::IDX_W;
    localparam int DW    = azn_pkg::DEG_W;

    logic                ch_valid [0:NS];
    logic                ch_ready [0:NS];
    logic [R2_W-1:0]     ch_r2    [0:NS];
    logic [Z2_W-1:0]     ch_z2    [0:NS];
    azn_pkg::azn_flags_t ch_flags [0:NS];
    logic [IW-1:0]       ch_acc   [0:NS];

    logic          res_valid_reg;
    logic [DW-1:0] deg_reg, deg_next;
    logic          ok_reg, ok_next;
    logic          ro;

    azn_front #(
        .SB (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .x_sample  (sample.x_sample),
        .y_sample  (sample.y_sample),
        .z_sample  (sample.z_sample),
        .out_valid (ch_valid[0]),
        .out_ready (ch_ready[0]),
        .r2        (ch_r2[0]),
        .z2        (ch_z2[0]),
        .flags     (ch_flags[0])
    );

    assign ch_acc[0] = '0;

    for (genvar i = 0; i < NS; i++)
    begin : g_cell
        azn_cell #(
            .SB   (SAMPLE_BITS),
            .STEP (NS-1-i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (ch_valid[i]),
            .in_ready  (ch_ready[i]),
            .r2_in     (ch_r2[i]),
            .z2_in     (ch_z2[i]),
            .flags_in  (ch_flags[i]),
            .acc_in    (ch_acc[i]),
            .out_valid (ch_valid[i+1]),
            .out_ready (ch_ready[i+1]),
            .r2_out    (ch_r2[i+1]),
            .z2_out    (ch_z2[i+1]),
            .flags_out (ch_flags[i+1]),
            .acc_out   (ch_acc[i+1])
        );
    end

    assign ro           = !res_valid_reg || result.ready;
    assign ch_ready[NS] = ro;

    // acc = first table entry the angle falls short of
    always_comb
    begin
        ok_next = 1'b1;
        if (ch_flags[NS].vec_zero)
        begin
            deg_next = azn_pkg::DEG_NONE;
            ok_next  = 1'b0;
        end
        else if (ch_flags[NS].z_zero)
            deg_next = azn_pkg::DEG_RIGHT;
        else if (ch_flags[NS].z_neg)
            deg_next = azn_pkg::DEG_HALF_TURN - DW'(ch_acc[NS]);
        else
            deg_next = DW'(ch_acc[NS]) - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (ro)
            res_valid_reg <= ch_valid[NS];
    end

    always_ff @(posedge clk)
    begin
        if (ro)
        begin
            deg_reg <= deg_next;
            ok_reg  <= ok_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.zenith_degrees = deg_reg;
    assign result.angle_valid    = ok_reg;

endmodule

`default_nettype wire

/* hw/rtl/azn_front.sv */
`default_nettype none

// Magnitudes, squares and |v|^2 in three stages.
module azn_front #(
    parameter int SB = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [azn_pkg::AXIS_W-1:0]    x_sample,
    input  logic [azn_pkg::AXIS_W-1:0]    y_sample,
    input  logic [azn_pkg::AXIS_W-1:0]    z_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2*SB-1:0]               r2,
    output logic [2*SB-2:0]               z2,
    output azn_pkg::azn_flags_t           flags
);

    localparam int MAG_W = SB;
    localparam int SQ_W  = 2*SB-1;
    localparam int R2_W  = 2*SB;

    function automatic logic [MAG_W-1:0] mag_of(input logic [azn_pkg::AXIS_W-1:0] raw);
        logic [MAG_W-1:0] f;
        f = raw[MAG_W-1:0];
        return f[MAG_W-1] ? MAG_W'(~f + 1'b1) : f;
    endfunction

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    logic [MAG_W-1:0] xm_reg, ym_reg, zm_reg;
    logic [MAG_W-1:0] xm_next, ym_next, zm_next;
    azn_pkg::azn_flags_t f1_reg, f1_next, f2_reg, f3_reg;
    logic [SQ_W-1:0] x2_reg, y2_reg, z2a_reg, z2b_reg;
    logic [SQ_W-1:0] x2_next, y2_next, z2_next;
    logic [R2_W-1:0] r2_reg, r2_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        xm_next = mag_of(x_sample);
        ym_next = mag_of(y_sample);
        zm_next = mag_of(z_sample);
        f1_next.z_neg    = z_sample[SB-1];
        f1_next.z_zero   = (zm_next == '0);
        f1_next.vec_zero = (xm_next == '0) && (ym_next == '0) && (zm_next == '0);
        x2_next = SQ_W'(xm_reg) * SQ_W'(xm_reg);
        y2_next = SQ_W'(ym_reg) * SQ_W'(ym_reg);
        z2_next = SQ_W'(zm_reg) * SQ_W'(zm_reg);
        r2_next = R2_W'(x2_reg) + R2_W'(y2_reg) + R2_W'(z2a_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            xm_reg <= xm_next;
            ym_reg <= ym_next;
            zm_reg <= zm_next;
            f1_reg <= f1_next;
        end
        if (rdy2)
        begin
            x2_reg  <= x2_next;
            y2_reg  <= y2_next;
            z2a_reg <= z2_next;
            f2_reg  <= f1_reg;
        end
        if (rdy3)
        begin
            r2_reg  <= r2_next;
            z2b_reg <= z2a_reg;
            f3_reg  <= f2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign r2        = r2_reg;
    assign z2        = z2b_reg;
    assign flags     = f3_reg;

endmodule

`default_nettype wire

/* hw/rtl/azn_cell.sv */
`default_nettype none

// One step of the bisection over the cos^2 table: fetch, multiply, compare.
// acc counts table entries the vector's angle is not short of.
module azn_cell #(
    parameter int SB   = 16,
    parameter int STEP = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2*SB-1:0]               r2_in,
    input  logic [2*SB-2:0]               z2_in,
    input  azn_pkg::azn_flags_t           flags_in,
    input  logic [azn_pkg::IDX_W-1:0]     acc_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2*SB-1:0]               r2_out,
    output logic [2*SB-2:0]               z2_out,
    output azn_pkg::azn_flags_t           flags_out,
    output logic [azn_pkg::IDX_W-1:0]     acc_out
);

    localparam int R2_W  = 2*SB;
    localparam int Z2_W  = 2*SB-1;
    localparam int FW    = azn_pkg::FRAC_W;
    localparam int P_W   = R2_W + FW;
    localparam int IW    = azn_pkg::IDX_W;
    localparam logic [IW-1:0] STEP_BIT = IW'(1) << STEP;
    localparam logic [IW-1:0] IDX_LAST = IW'(azn_pkg::TAB_LAST);

    logic va_reg, vb_reg, vc_reg;
    logic ra, rb, rc;

    logic [IW-1:0] cand_next, idx;
    logic          chk_next, one_next;
    logic [FW-1:0] c2_next;

    logic [R2_W-1:0] r2_a_reg, r2_b_reg, r2_c_reg;
    logic [Z2_W-1:0] z2_a_reg, z2_b_reg, z2_c_reg;
    azn_pkg::azn_flags_t fl_a_reg, fl_b_reg, fl_c_reg;
    logic [IW-1:0]   acc_a_reg, acc_b_reg, acc_c_reg, acc_next;
    logic [IW-1:0]   cand_a_reg, cand_b_reg;
    logic            chk_a_reg, chk_b_reg, one_a_reg;
    logic [FW-1:0]   c2_a_reg;
    logic [P_W-1:0]  prod_reg, prod_next;
    logic [P_W-1:0]  z2s;
    logic            passed;

    assign rc       = !vc_reg || out_ready;
    assign rb       = !vb_reg || rc;
    assign ra       = !va_reg || rb;
    assign in_ready = ra;

    always_comb
    begin
        cand_next = acc_in | STEP_BIT;
        idx       = cand_next - 1'b1;
        chk_next  = (idx <= IDX_LAST);
        one_next  = (idx == '0);
        c2_next   = chk_next ? azn_pkg::COS_SQ_Q32[idx] : '0;

        // entry 0 is exactly 1.0
        if (one_a_reg)
            prod_next = {r2_a_reg, FW'(0)};
        else
            prod_next = r2_a_reg * c2_a_reg;

        // angle lies short of the tested entry; on the negative side equality counts
        z2s = {1'b0, z2_b_reg, FW'(0)};
        if (fl_b_reg.z_neg)
            passed = (z2s >= prod_reg);
        else
            passed = (z2s > prod_reg);
        acc_next = (chk_b_reg && !passed) ? cand_b_reg : acc_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (ra) va_reg <= in_valid;
            if (rb) vb_reg <= va_reg;
            if (rc) vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ra)
        begin
            r2_a_reg   <= r2_in;
            z2_a_reg   <= z2_in;
            fl_a_reg   <= flags_in;
            acc_a_reg  <= acc_in;
            cand_a_reg <= cand_next;
            chk_a_reg  <= chk_next;
            one_a_reg  <= one_next;
            c2_a_reg   <= c2_next;
        end
        if (rb)
        begin
            r2_b_reg   <= r2_a_reg;
            z2_b_reg   <= z2_a_reg;
            fl_b_reg   <= fl_a_reg;
            acc_b_reg  <= acc_a_reg;
            cand_b_reg <= cand_a_reg;
            chk_b_reg  <= chk_a_reg;
            prod_reg   <= prod_next;
        end
        if (rc)
        begin
            r2_c_reg  <= r2_b_reg;
            z2_c_reg  <= z2_b_reg;
            fl_c_reg  <= fl_b_reg;
            acc_c_reg <= acc_next;
        end
    end

    assign out_valid = vc_reg;
    assign r2_out    = r2_c_reg;
    assign z2_out    = z2_c_reg;
    assign flags_out = fl_c_reg;
    assign acc_out   = acc_c_reg;

endmodule

`default_nettype wire

/* hw/rtl/azn_check.sv */
`default_nettype none

`include "assert_macros.svh"

module azn_check (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    input  wire                        in_ready,
    input  wire                        out_valid,
    input  wire                        out_ready,
    input  wire [azn_pkg::DEG_W-1:0]   zenith_degrees,
    input  wire                        angle_valid
);

    localparam int CNT_W = 6;

    logic [CNT_W-1:0] pending_reg, pending_next;

    // requests taken but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_valid && in_ready)
            pending_next = pending_next + 1'b1;
        if (out_valid && out_ready)
            pending_next = pending_next - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    `AZN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `AZN_ASSERT_IMP(a_deg_range, clk, rst_n, out_valid, zenith_degrees <= azn_pkg::DEG_HALF_TURN)
    `AZN_ASSERT_IMP(a_zero_vec, clk, rst_n, out_valid && !angle_valid, zenith_degrees == azn_pkg::DEG_NONE)
    `AZN_ASSERT_IMP(a_has_cause, clk, rst_n, out_valid, pending_reg != '0)

endmodule

bind accel_zenith_angle azn_check u_azn_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sample.valid),
    .in_ready       (sample.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .zenith_degrees (result.zenith_degrees),
    .angle_valid    (result.angle_valid)
);

`default_nettype wire

/* test/accel_zenith_angle_checker.sv */
`default_nettype none

module accel_zenith_angle_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    azn_sample_if   sample,
    azn_result_if   result,
    output int      mismatch_count,
    output int      angles_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          AXIS_BITS    = azn_pkg::AXIS_W;
    localparam int          DEG_BITS     = azn_pkg::DEG_W;
    localparam logic [63:0] ONE_Q31      = 64'd2147483648;
    localparam logic [63:0] COS_1DEG_Q31 = 64'd2147156576;
    localparam logic [63:0] SIN_1DEG_Q31 = 64'd37478757;
    localparam logic [63:0] HALF_LSB_Q31 = 64'd1 << 30;
    localparam logic [63:0] UNIT_Q32     = 64'd1 << 32;
    localparam int          OCTANT_DEG   = 45;
    localparam int          RIGHT_DEG    = 90;
    localparam int          LAST_DEG     = 180;

    typedef struct packed {
        logic [DEG_BITS-1:0] degrees;
        logic                valid;
    } zenith_t;

    // cos^2 of whole degrees 0..90, Q32 (entry 0 is exactly 1.0)
    logic [63:0] cos_sq_q32 [0:RIGHT_DEG];
    zenith_t     zenith_q [$];
    zenith_t     want;
    zenith_t     seen;

    initial
    begin : cos_table
        logic [63:0] c;
        logic [63:0] s;
        logic [63:0] c_next;
        logic [63:0] s_next;
        logic [63:0] cos_q31 [0:OCTANT_DEG];
        logic [63:0] sin_q31 [0:OCTANT_DEG];
        c = ONE_Q31;
        s = '0;
        cos_q31[0] = c;
        sin_q31[0] = s;
        // rotate by one degree at a time, rounding half up in Q31
        for (int k = 1; k <= OCTANT_DEG; k++)
        begin
            c_next = (c * COS_1DEG_Q31 - s * SIN_1DEG_Q31 + HALF_LSB_Q31) >> 31;
            s_next = (s * COS_1DEG_Q31 + c * SIN_1DEG_Q31 + HALF_LSB_Q31) >> 31;
            c = c_next;
            s = s_next;
            cos_q31[k] = c;
            sin_q31[k] = s;
        end
        for (int k = 0; k <= OCTANT_DEG; k++)
            cos_sq_q32[k] = (cos_q31[k] * cos_q31[k]) >> 30;
        for (int k = OCTANT_DEG + 1; k <= RIGHT_DEG; k++)
            cos_sq_q32[k] = (sin_q31[RIGHT_DEG-k] * sin_q31[RIGHT_DEG-k]) >> 30;
        cos_sq_q32[0]         = UNIT_Q32;
        cos_sq_q32[30]        = 64'd3 << 30;
        cos_sq_q32[45]        = 64'd1 << 31;
        cos_sq_q32[60]        = 64'd1 << 30;
        cos_sq_q32[RIGHT_DEG] = '0;
    end

    function automatic logic [63:0] axis_magnitude(input logic [AXIS_BITS-1:0] raw,
                                                    output logic neg);
        logic [63:0] field;
        field = 64'(raw) & ((64'd1 << SAMPLE_BITS) - 64'd1);
        neg   = field[SAMPLE_BITS-1];
        return neg ? (64'd1 << SAMPLE_BITS) - field : field;
    endfunction

    // largest d with z <= |v| cos(d), tested on squares with the sign of z
    function automatic zenith_t predict_zenith(input logic [AXIS_BITS-1:0] xr,
                                               input logic [AXIS_BITS-1:0] yr,
                                               input logic [AXIS_BITS-1:0] zr);
        logic        xn;
        logic        yn;
        logic        zn;
        logic        fits;
        logic [63:0] xm;
        logic [63:0] ym;
        logic [63:0] zm;
        logic [63:0] z_sq;
        logic [63:0] r_sq;
        zenith_t     res;
        xm   = axis_magnitude(xr, xn);
        ym   = axis_magnitude(yr, yn);
        zm   = axis_magnitude(zr, zn);
        z_sq = zm * zm;
        r_sq = xm * xm + ym * ym + z_sq;
        res.degrees = azn_pkg::DEG_NONE;
        res.valid   = 1'b0;
        if (r_sq == 64'd0)
            return res;
        res.valid = 1'b1;
        for (int d = 1; d <= LAST_DEG; d++)
        begin
            if (d <= RIGHT_DEG)
                fits = zn || zm == 64'd0 || (z_sq << 32) <= r_sq * cos_sq_q32[d];
            else
                fits = zn && (z_sq << 32) >= r_sq * cos_sq_q32[LAST_DEG-d];
            if (fits)
                res.degrees = DEG_BITS'(d);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zenith_q.delete();
            mismatch_count <= 0;
            angles_pending <= 0;
        end
        else
        begin
            if (sample.valid && sample.ready)
                zenith_q.push_back(predict_zenith(sample.x_sample, sample.y_sample,
                                                  sample.z_sample));
            if (result.valid && result.ready)
            begin
                seen.degrees = result.zenith_degrees;
                seen.valid   = result.angle_valid;
                if (zenith_q.size() == 0)
                begin
                    $display("%0t: unrequested angle: expected none, got deg=%0d valid=%0b",
                             $time, seen.degrees, seen.valid);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = zenith_q.pop_front();
                    if (seen.degrees !== want.degrees || seen.valid !== want.valid)
                    begin
                        $display({"%0t: angle mismatch: expected deg=%0d valid=%0b, ",
                                  "got deg=%0d valid=%0b"},
                                 $time, want.degrees, want.valid, seen.degrees, seen.valid);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            angles_pending <= zenith_q.size();
        end
    end

endmodule

`default_nettype wire

/* test/accel_zenith_angle_tb.sv */
`default_nettype none

module accel_zenith_angle_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS  = 16;
    localparam int AXIS_BITS    = azn_pkg::AXIS_W;
    localparam int RANDOM_ITEMS = 200;
    localparam int PHASES       = 4;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 300000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   mismatches;
    int   pending_angles;
    int   cycle_count = 0;
    int   burst_left  = 0;
    bit   gaps_on     = 1'b0;

    azn_sample_if sample_ch ();
    azn_result_if result_ch ();

    accel_zenith_angle #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    accel_zenith_angle_checker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample_ch),
        .result         (result_ch),
        .mismatch_count (mismatches),
        .angles_pending (pending_angles)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[accel_zenith_angle] ERROR");
            $finish;
        end
    end

    // result side: ready follows one of four stall patterns, picked anew at random
    initial
    begin
        int mode;
        int hold;
        mode = 0;
        hold = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                mode = $urandom_range(0, 3);
                hold = $urandom_range(20, 200);
            end
            hold--;
            case (mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= 1'($urandom_range(0, 1));
                2:       result_ch.ready <= ($urandom_range(0, 5) == 0);
                default: result_ch.ready <= (hold % 24) < 12;
            endcase
        end
    end

    task automatic send_sample(input logic [AXIS_BITS-1:0] xs,
                               input logic [AXIS_BITS-1:0] ys,
                               input logic [AXIS_BITS-1:0] zs);
        if (gaps_on && burst_left == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        sample_ch.valid    <= 1'b1;
        sample_ch.x_sample <= xs;
        sample_ch.y_sample <= ys;
        sample_ch.z_sample <= zs;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_for_angles();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_angles != 0)
            @(posedge clk);
    endtask

    function automatic logic [AXIS_BITS-1:0] extreme_value();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h8001;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    function automatic logic [AXIS_BITS-1:0] near_zero(input int span);
        int v;
        v = $urandom_range(0, 2 * span);
        return AXIS_BITS'(v - span);
    endfunction

    task automatic send_random_sample();
        logic [AXIS_BITS-1:0] xs;
        logic [AXIS_BITS-1:0] ys;
        logic [AXIS_BITS-1:0] zs;
        xs = AXIS_BITS'($urandom);
        ys = AXIS_BITS'($urandom);
        zs = AXIS_BITS'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3:
            begin
                xs = near_zero(8);
                ys = near_zero(8);
                zs = near_zero(8);
            end
            4:
            begin
                // single axis
                case ($urandom_range(0, 2))
                    0:       begin ys = '0; zs = '0; end
                    1:       begin xs = '0; zs = '0; end
                    default: begin xs = '0; ys = '0; end
                endcase
            end
            5:
            begin
                // close to vertical, either way up
                xs = near_zero(64);
                ys = near_zero(64);
            end
            6:
            begin
                // around 45 and 135 degrees
                zs = near_zero(30000);
                xs = $urandom_range(0, 1) ? zs : -zs;
                ys = near_zero(4);
            end
            7:
            begin
                xs = extreme_value();
                ys = extreme_value();
                zs = extreme_value();
            end
            8:
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    xs = '0;
                    ys = '0;
                    zs = '0;
                end
                else
                begin
                    xs = near_zero(2);
                    ys = near_zero(2);
                    zs = near_zero(2);
                end
            end
            default:
            begin
                xs = near_zero(1000);
                ys = near_zero(1000);
                zs = near_zero(1000);
            end
        endcase
        send_sample(xs, ys, zs);
    endtask

    initial
    begin
        sample_ch.valid    <= 1'b0;
        sample_ch.x_sample <= '0;
        sample_ch.y_sample <= '0;
        sample_ch.z_sample <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gaps_on = 1'b1;
        send_sample(16'h0000, 16'h0000, 16'h0000);   // zero vector
        send_sample(16'h0000, 16'h0000, 16'h0001);   // straight up
        send_sample(16'h0000, 16'h0000, 16'hFFFF);   // straight down
        send_sample(16'h0000, 16'h0000, 16'h7FFF);
        send_sample(16'h0000, 16'h0000, 16'h8000);
        send_sample(16'h0001, 16'h0000, 16'h0000);   // horizontal
        send_sample(16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h8000, 16'h0000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h0000);
        send_sample(16'd1000, 16'h0000, 16'd1000);   // 45 exactly
        send_sample(16'd1000, 16'h0000, -16'd1000);  // 135 exactly
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h7FFF);
        send_sample(16'h0001, 16'h0001, 16'h0001);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'h0001, 16'h0000, 16'h8000);   // just off straight down
        send_sample(16'h0001, 16'h0000, 16'h7FFF);   // just off straight up
        send_sample(16'h7FFF, 16'h0000, 16'h0001);   // just above horizontal
        send_sample(16'h7FFF, 16'h0000, 16'hFFFF);   // just below horizontal
        send_sample(16'h5555, 16'hAAAA, 16'h5555);
        send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
        wait_for_angles();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            gaps_on = (phase != 0);
            for (int i = 0; i < RANDOM_ITEMS; i++)
                send_random_sample();
            if (phase == 1)
                wait_for_angles();
        end

        wait_for_angles();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_angles == 0)
            $display("[accel_zenith_angle] OK");
        else
            $display("[accel_zenith_angle] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* accel_zenith_angle.f */
+incdir+hw/rtl
hw/rtl/azn_pkg.sv
hw/rtl/azn_ifaces.sv
hw/rtl/azn_front.sv
hw/rtl/azn_cell.sv
hw/rtl/accel_zenith_angle.sv
hw/rtl/azn_check.sv
test/accel_zenith_angle_checker.sv
test/accel_zenith_angle_tb.sv
